// File: design/vau_pkg.sv
// Shared types and constants for the three-component vector ALU.
package vau_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int NUM_W      = 32 + FRAC_BITS;
  localparam int ROOT_STEPS = 32;
  localparam int STEP_W     = $clog2(NUM_W + 1);

  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 2;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_SUB   = 3'd1;
  localparam logic [2:0] OP_SCALE = 3'd2;
  localparam logic [2:0] OP_DOT   = 3'd3;
  localparam logic [2:0] OP_CROSS = 3'd4;
  localparam logic [2:0] OP_LEN   = 3'd5;
  localparam logic [2:0] OP_NORM  = 3'd6;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_DIVZ = 2'd2;

  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] a_x;
    logic signed [31:0] a_y;
    logic signed [31:0] a_z;
    logic signed [31:0] b_x;
    logic signed [31:0] b_y;
    logic signed [31:0] b_z;
    logic signed [31:0] scale_factor;
  } vau_item_t;

  typedef struct packed {
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic signed [31:0] r_z;
    logic signed [31:0] scalar_result;
    logic [1:0]         status;
  } vau_result_t;

  typedef struct packed {
    vau_item_t item;
    logic      slow;
  } vau_job_t;

  typedef struct packed {
    logic               done;
    logic [31:0]        len;
    logic [NUM_W-1:0]   q_x;
    logic [NUM_W-1:0]   q_y;
    logic [NUM_W-1:0]   q_z;
    logic [2:0]         neg;
  } vau_root_t;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] value;
  } vau_sat_t;

endpackage

// File: design/vau_front.sv
// Front end: accept items, tag slow operations, and queue them for the back end.
module vau_front import vau_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  vau_item_t item,
  output logic      job_valid,
  output vau_job_t  job,
  input  logic      take
);

  vau_job_t              fq [FQ_DEPTH];
  logic [FQ_PTR_W-1:0]   wr_ptr;
  logic [FQ_PTR_W-1:0]   rd_ptr;
  logic [FQ_CNT_W-1:0]   cnt;
  logic                  wr_en;
  logic                  rd_en;
  logic                  slow;

  always_comb begin
    unique case (item.operation) inside
      OP_LEN, OP_NORM: slow = 1'b1;
      default:         slow = 1'b0;
    endcase
  end

  assign full      = (cnt == FQ_CNT_W'(FQ_DEPTH));
  assign job_valid = (cnt != '0);
  assign job       = fq[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = take && job_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fq[wr_ptr] <= '{item: item, slow: slow};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      cnt <= cnt + FQ_CNT_W'(wr_en) - FQ_CNT_W'(rd_en);
    end
  end

  a_fq_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= FQ_CNT_W'(FQ_DEPTH))
    else $error("front queue count out of range");

endmodule

// File: design/vau_root.sv
// Iterative square root and three-lane restoring divider for length and normalize.
module vau_root import vau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               norm,
  input  logic [63:0]        radicand,
  input  logic signed [31:0] a_x,
  input  logic signed [31:0] a_y,
  input  logic signed [31:0] a_z,
  output vau_root_t          rout
);

  localparam logic [1:0] RS_IDLE = 2'd0;
  localparam logic [1:0] RS_SQRT = 2'd1;
  localparam logic [1:0] RS_DIV  = 2'd2;
  localparam logic [1:0] RS_DONE = 2'd3;

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  logic              norm_q;
  logic [2:0]        neg;
  logic [63:0]       rad;
  logic [33:0]       rem_s;
  logic [31:0]       root;
  logic [NUM_W-1:0]  num  [3];
  logic [31:0]       drem [3];

  logic [35:0]       rem_sh;
  logic [35:0]       trial;
  logic [35:0]       sq_dif;
  logic              sq_ge;
  logic [31:0]       root_next;
  logic [32:0]       rsh  [3];
  logic [32:0]       dif  [3];
  logic              dge  [3];
  logic [31:0]       mag  [3];
  logic signed [31:0] a_in [3];

  assign a_in[0] = a_x;
  assign a_in[1] = a_y;
  assign a_in[2] = a_z;

  always_comb begin
    rem_sh    = {rem_s, rad[63:62]};
    trial     = {2'b00, root, 2'b01};
    sq_dif    = rem_sh - trial;
    sq_ge     = (rem_sh >= trial);
    root_next = {root[30:0], sq_ge};
    for (int i = 0; i < 3; i++) begin
      mag[i] = a_in[i][31] ? (~a_in[i] + 32'd1) : a_in[i];
      rsh[i] = {drem[i], num[i][NUM_W-1]};
      dif[i] = rsh[i] - {1'b0, root};
      dge[i] = (rsh[i] >= {1'b0, root});
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad    <= radicand;
      rem_s  <= '0;
      root   <= '0;
      norm_q <= norm;
      neg    <= {a_z[31], a_y[31], a_x[31]};
      for (int i = 0; i < 3; i++) begin
        num[i]  <= {mag[i], {FRAC_BITS{1'b0}}};
        drem[i] <= '0;
      end
    end else if (state == RS_SQRT) begin
      rad   <= {rad[61:0], 2'b00};
      rem_s <= sq_ge ? sq_dif[33:0] : rem_sh[33:0];
      root  <= root_next;
    end else if (state == RS_DIV) begin
      for (int i = 0; i < 3; i++) begin
        drem[i] <= dge[i] ? dif[i][31:0] : rsh[i][31:0];
        num[i]  <= {num[i][NUM_W-2:0], dge[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= RS_IDLE;
      step  <= '0;
    end else if (start) begin
      state <= RS_SQRT;
      step  <= '0;
    end else begin
      unique case (state)
        RS_SQRT: begin
          step <= step + 1'b1;
          if (step == STEP_W'(ROOT_STEPS - 1)) begin
            step  <= '0;
            state <= (norm_q && (root_next != '0)) ? RS_DIV : RS_DONE;
          end
        end
        RS_DIV: begin
          step <= step + 1'b1;
          if (step == STEP_W'(NUM_W - 1)) begin
            state <= RS_DONE;
          end
        end
        default: begin
          step <= '0;
        end
      endcase
    end
  end

  assign rout = '{done: (state == RS_DONE), len: root, q_x: num[0], q_y: num[1],
                  q_z: num[2], neg: neg};

  a_start_sqrt: assert property (@(posedge clk) disable iff (rst)
    start |=> (state == RS_SQRT))
    else $error("root unit did not begin after start");

endmodule

// File: design/vau_back.sv
// Back end: multiply stage, reduce and saturate stage, root unit and result queue.
module vau_back import vau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        job_valid,
  input  vau_job_t    job,
  output logic        take,
  output logic        empty,
  input  logic        pop,
  output vau_result_t result
);

  function automatic vau_sat_t clamp64(input logic signed [63:0] v);
    vau_sat_t r;
    if (v[63:31] == {33{v[63]}}) begin
      r.sat   = 1'b0;
      r.value = v[31:0];
    end else if (v[63]) begin
      r.sat   = 1'b1;
      r.value = SAT_MIN;
    end else begin
      r.sat   = 1'b1;
      r.value = SAT_MAX;
    end
    return r;
  endfunction

  function automatic vau_sat_t qclamp(input logic [NUM_W-1:0] q, input logic neg);
    vau_sat_t r;
    r.sat   = 1'b0;
    r.value = neg ? (~q[31:0] + 32'd1) : q[31:0];
    if (!neg && (q[NUM_W-1:31] != '0)) begin
      r.sat   = 1'b1;
      r.value = SAT_MAX;
    end
    if (neg && ((q[NUM_W-1:32] != '0) || (q[31] && (q[30:0] != '0)))) begin
      r.sat   = 1'b1;
      r.value = SAT_MIN;
    end
    return r;
  endfunction

  vau_item_t          h;
  logic signed [31:0] sel [3];
  logic signed [63:0] prod [6];
  logic signed [32:0] sums [3];

  logic               p1_valid;
  vau_job_t           p1_job;
  logic signed [63:0] p1_prod [6];
  logic signed [32:0] p1_sum  [3];

  logic signed [63:0] red [6];
  logic signed [63:0] vx, vy, vz, vs;
  logic [63:0]        rad;
  vau_sat_t           cx, cy, cz, cs;

  logic               p2_valid;
  logic               p2_slow;
  logic               p2_norm;
  vau_result_t        p2_res;

  vau_root_t          rout;
  logic               root_start;
  vau_result_t        slow_res;
  vau_result_t        p2_out;
  vau_sat_t           qx, qy, qz;

  vau_result_t           oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_wr;
  logic [OQ_PTR_W-1:0]   oq_rd;
  logic [OQ_CNT_W-1:0]   oq_cnt;
  logic                  oq_full;
  logic                  oq_push;
  logic                  oq_pop;
  logic                  p2_ready;
  logic                  p2_free;
  logic                  p1_adv;
  logic                  p1_free;

  assign oq_full  = (oq_cnt == OQ_CNT_W'(OQ_DEPTH));
  assign empty    = (oq_cnt == '0);
  assign result   = oq[oq_rd];
  assign oq_pop   = pop && !empty;
  assign p2_ready = !p2_slow || rout.done;
  assign oq_push  = p2_valid && p2_ready && !oq_full;
  assign p2_free  = !p2_valid || oq_push;
  assign p1_adv   = p1_valid && p2_free;
  assign p1_free  = !p1_valid || p2_free;
  assign take     = job_valid && p1_free;
  assign root_start = p1_adv && p1_job.slow;

  // operand select and products
  always_comb begin
    h = job.item;
    unique case (h.operation)
      OP_SCALE: begin
        sel[0] = h.scale_factor;
        sel[1] = h.scale_factor;
        sel[2] = h.scale_factor;
      end
      OP_LEN, OP_NORM: begin
        sel[0] = h.a_x;
        sel[1] = h.a_y;
        sel[2] = h.a_z;
      end
      OP_CROSS: begin
        sel[0] = h.b_y;
        sel[1] = h.b_z;
        sel[2] = h.b_x;
      end
      default: begin
        sel[0] = h.b_x;
        sel[1] = h.b_y;
        sel[2] = h.b_z;
      end
    endcase
    prod[0] = h.a_x * sel[0];
    prod[1] = h.a_y * sel[1];
    prod[2] = h.a_z * sel[2];
    prod[3] = h.a_y * h.b_x;
    prod[4] = h.a_z * h.b_y;
    prod[5] = h.a_x * h.b_z;
    if (h.operation == OP_SUB) begin
      sums[0] = {h.a_x[31], h.a_x} - {h.b_x[31], h.b_x};
      sums[1] = {h.a_y[31], h.a_y} - {h.b_y[31], h.b_y};
      sums[2] = {h.a_z[31], h.a_z} - {h.b_z[31], h.b_z};
    end else begin
      sums[0] = {h.a_x[31], h.a_x} + {h.b_x[31], h.b_x};
      sums[1] = {h.a_y[31], h.a_y} + {h.b_y[31], h.b_y};
      sums[2] = {h.a_z[31], h.a_z} + {h.b_z[31], h.b_z};
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      p1_job <= job;
      for (int k = 0; k < 6; k++) begin
        p1_prod[k] <= prod[k];
      end
      for (int k = 0; k < 3; k++) begin
        p1_sum[k] <= sums[k];
      end
    end
  end

  // reduce, combine and saturate
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      red[k] = p1_prod[k] >>> FRAC_BITS;
    end
    rad = p1_prod[0] + p1_prod[1] + p1_prod[2];
    vx  = '0;
    vy  = '0;
    vz  = '0;
    vs  = '0;
    unique case (p1_job.item.operation)
      OP_ADD, OP_SUB: begin
        vx = 64'(p1_sum[0]);
        vy = 64'(p1_sum[1]);
        vz = 64'(p1_sum[2]);
      end
      OP_SCALE: begin
        vx = red[0];
        vy = red[1];
        vz = red[2];
      end
      OP_DOT: begin
        vs = red[0] + red[1] + red[2];
      end
      OP_CROSS: begin
        vx = red[1] - red[4];
        vy = red[2] - red[5];
        vz = red[0] - red[3];
      end
      default: begin
        vs = '0;
      end
    endcase
    cx = clamp64(vx);
    cy = clamp64(vy);
    cz = clamp64(vz);
    cs = clamp64(vs);
  end

  always_ff @(posedge clk) begin
    if (p1_adv) begin
      p2_slow <= p1_job.slow;
      p2_norm <= (p1_job.item.operation == OP_NORM);
      p2_res  <= '{r_x: cx.value, r_y: cy.value, r_z: cz.value, scalar_result: cs.value,
                   status: (cx.sat || cy.sat || cz.sat || cs.sat) ? STAT_SAT : STAT_OK};
    end
  end

  vau_root u_root (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .norm     (p1_job.item.operation == OP_NORM),
    .radicand (rad),
    .a_x      (p1_job.item.a_x),
    .a_y      (p1_job.item.a_y),
    .a_z      (p1_job.item.a_z),
    .rout     (rout)
  );

  always_comb begin
    qx = qclamp(rout.q_x, rout.neg[0]);
    qy = qclamp(rout.q_y, rout.neg[1]);
    qz = qclamp(rout.q_z, rout.neg[2]);
    slow_res = '0;
    if (!p2_norm) begin
      slow_res.scalar_result = rout.len[31] ? SAT_MAX : rout.len;
      slow_res.status        = rout.len[31] ? STAT_SAT : STAT_OK;
    end else if (rout.len == '0) begin
      slow_res.status = STAT_DIVZ;
    end else begin
      slow_res.r_x    = qx.value;
      slow_res.r_y    = qy.value;
      slow_res.r_z    = qz.value;
      slow_res.status = (qx.sat || qy.sat || qz.sat) ? STAT_SAT : STAT_OK;
    end
    p2_out = p2_slow ? slow_res : p2_res;
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wr] <= p2_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_cnt   <= '0;
    end else begin
      if (p1_free) begin
        p1_valid <= take;
      end
      if (p2_free) begin
        p2_valid <= p1_adv;
      end
      if (oq_push) begin
        oq_wr <= oq_wr + 1'b1;
      end
      if (oq_pop) begin
        oq_rd <= oq_rd + 1'b1;
      end
      oq_cnt <= oq_cnt + OQ_CNT_W'(oq_push) - OQ_CNT_W'(oq_pop);
    end
  end

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_cnt <= OQ_CNT_W'(OQ_DEPTH))
    else $error("result queue count out of range");

  a_slow_hold: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && p2_slow && !rout.done) |=> (p2_valid && p2_slow))
    else $error("slow item left stage before root unit finished");

  a_fast_hold: assert property (@(posedge clk) disable iff (rst)
    (p2_valid && !p2_slow && !oq_push) |=> (p2_valid && $stable(p2_res)))
    else $error("stalled result changed");

endmodule

// File: design/vec3_arithmetic_unit.sv
// Top level of the three-component Q16.16 vector ALU.
// Add, subtract, scale, dot and cross flow through a multiply stage and a
// reduce/saturate stage at one beat per cycle while neither stage is held by a slow
// item or a full result queue; a result passes both stage registers and the result
// queue before it shows on the output. Length holds the back end while the
// one-bit-per-cycle square-root and divider unit takes its root, and normalize also
// while it divides; the front queue keeps taking beats meanwhile until its four entries fill.
// There is no clearing pass after reset.
module vec3_arithmetic_unit import vau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  vau_item_t   item,
  output logic        empty,
  input  logic        pop,
  output vau_result_t result
);

  logic     job_valid;
  vau_job_t job;
  logic     take;

  vau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .job_valid (job_valid),
    .job       (job),
    .take      (take)
  );

  vau_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

endmodule
